// ===== rtl/dedup_fifo_queue_core_macros.svh =====
// Assertion macros of the duplicate-rejecting queue RTL.
`ifndef DEDUP_FIFO_QUEUE_CORE_MACROS_SVH
`define DEDUP_FIFO_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge outside reset.
`define DFQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define DFQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DFQ_ASSERT_ALWAYS(lbl, expr, msg)
`define DFQ_ASSERT_SAME(lbl, ante, cons, msg)
`define DFQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/dfq_pkg.sv =====
// Types, constants and helper functions of the duplicate-rejecting queue.
package dfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int OCC_W       = 7;
  localparam int STS_W       = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [STS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DUP   = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } dfq_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEQ,
    ST_FINISH
  } dfq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the beat and arm the search
    logic scan;    // step the duplicate search
    logic deq_rd;  // read the head slot
    logic commit;  // update the queue and load the result register
  } dfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } dfq_sts_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

endpackage

// ===== rtl/dedup_fifo_queue_core.sv =====
// Top level of the FIFO queue that refuses values it already holds.
//
//   Channel  Direction  Handshake              Fields
//   cmd      in         cmd_valid / cmd_stall  command, value_in
//   rsp      out        rsp_valid / rsp_stall  status, value_out, occupancy
//
// An enqueue beat searches the values held before its result is returned: the search reads
// one held slot per cycle through the single read port of the slot memory and stops early
// on a duplicate. A dequeue beat reads the head slot and then commits. Reset clears head,
// tail and count, not the slot memory.
// A new command beat is taken while a result still waits on rsp, but it is only
// completed once that waiting result has been taken.
module dedup_fifo_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic                             command,
  input  logic signed [dfq_pkg::VAL_W-1:0] value_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [dfq_pkg::STS_W-1:0]        status,
  output logic signed [dfq_pkg::VAL_W-1:0] value_out,
  output logic [dfq_pkg::OCC_W-1:0]        occupancy
);
  import dfq_pkg::*;

  // The controller sequences each beat: capture, search or head read, then
  // the commit that updates the queue and loads the result register.
  dfq_cmd_t ctrl_cmd;
  dfq_sts_t dp_sts;

  dfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (command),
    .cmd_stall (cmd_stall),
    .sts       (dp_sts),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds the slot memory, the circular pointers, the running
  // search over held slots and the result register that feeds rsp.
  dfq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .value_in  (value_in),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .status    (status),
    .value_out (value_out),
    .occupancy (occupancy),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts)
  );

endmodule

// ===== rtl/dfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dfq_ctrl.sv =====
// Controller state machine of the duplicate-rejecting queue.
module dfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              command,
  output logic              cmd_stall,
  input  dfq_pkg::dfq_sts_t sts,
  output dfq_pkg::dfq_cmd_t cmd
);
  import dfq_pkg::*;

  dfq_state_t state;
  dfq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (command == CMD_ENQ) ? ST_SCAN : ST_DEQ;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_DEQ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        cmd.load  = cmd_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DEQ: begin
        cmd.deq_rd = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/dfq_dp.sv =====
// Datapath of the duplicate-rejecting queue: slot memory, pointers, search and result.
`include "dedup_fifo_queue_core_macros.svh"

module dfq_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             command,
  input  logic signed [dfq_pkg::VAL_W-1:0] value_in,
  input  logic                             rsp_stall,
  output logic                             rsp_valid,
  output logic [dfq_pkg::STS_W-1:0]        status,
  output logic signed [dfq_pkg::VAL_W-1:0] value_out,
  output logic [dfq_pkg::OCC_W-1:0]        occupancy,
  input  dfq_pkg::dfq_cmd_t                cmd,
  output dfq_pkg::dfq_sts_t                sts
);
  import dfq_pkg::*;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             pend;
  logic             hit;

  logic             cmd_reg;
  logic [VAL_W-1:0] val_reg;
  logic [IDX_W-1:0] scan_ptr;
  logic [CNT_W-1:0] scan_left;

  logic             scan_issue;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic             wr_en;
  logic             full;
  logic             empty;
  logic             deq_ok;
  logic [CNT_W-1:0] count_next;
  dfq_status_t      status_next;

  dfq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (val_reg),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    full       = (count == CNT_W'(QUEUE_DEPTH));
    empty      = (count == '0);
    scan_issue = cmd.scan && (scan_left != '0) && !hit;
    rd_en      = scan_issue || cmd.deq_rd;
    rd_addr    = cmd.deq_rd ? head : scan_ptr;
    deq_ok     = (cmd_reg == CMD_DEQ) && !empty;
    wr_en      = cmd.commit && (cmd_reg == CMD_ENQ) && !hit && !full;

    sts.scan_done = !pend && ((scan_left == '0) || hit);
    sts.out_busy  = rsp_valid && rsp_stall;

    // The search result takes precedence over the full check.
    count_next  = count;
    status_next = STATUS_OK;
    if (cmd_reg == CMD_ENQ) begin
      if (hit) begin
        status_next = STATUS_DUP;
      end else if (full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.commit || (rsp_valid && rsp_stall);
      if (cmd.load) begin
        pend <= 1'b0;
        hit  <= 1'b0;
      end else if (cmd.scan) begin
        pend <= scan_issue;
        if (pend && (rd_data == val_reg)) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count <= count_next;
        if (wr_en) begin
          tail <= next_idx(tail);
        end
        if (deq_ok) begin
          head <= next_idx(head);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_reg   <= command;
      val_reg   <= value_in;
      scan_ptr  <= head;
      scan_left <= count;
    end else if (scan_issue) begin
      scan_ptr  <= next_idx(scan_ptr);
      scan_left <= scan_left - CNT_W'(1);
    end
    if (cmd.commit) begin
      status    <= status_next;
      value_out <= deq_ok ? $signed(rd_data) : '0;
      occupancy <= OCC_W'(count_next);
    end
  end

  `DFQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "held count beyond depth")
  `DFQ_ASSERT_NEXT(a_dup_keeps_count, cmd.commit && hit && (cmd_reg == CMD_ENQ), count == $past(count), "duplicate changed the count")
  `DFQ_ASSERT_SAME(a_write_not_full, wr_en, !full && !hit, "slot written on a refused enqueue")
  `DFQ_ASSERT_SAME(a_empty_zero, rsp_valid && (status == STATUS_EMPTY), value_out == '0, "empty result carries a value")

endmodule
